[rtl/core/ttsb_pkg.sv]
// Shared types, constants and helper functions for the text terminal screen buffer.
package ttsb_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 16;
    localparam int CELL_DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(CELL_DEPTH);
    localparam int COL_W       = 6;
    localparam int ROW_W       = 4;
    localparam int GEO_COL_W   = $clog2(MAX_COLUMNS + 1);
    localparam int GEO_ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int BASE_W      = ADDR_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BLANK_CELL = 8'd32;
    localparam logic [7:0] RESET_CELL = 8'd0;

    localparam logic [2:0] OP_PUT_CHAR    = 3'd0;
    localparam logic [2:0] OP_NEWLINE     = 3'd1;
    localparam logic [2:0] OP_CLEAR       = 3'd2;
    localparam logic [2:0] OP_MOVE        = 3'd3;
    localparam logic [2:0] OP_READ        = 3'd4;
    localparam logic [2:0] OP_CLEAR_DIRTY = 3'd5;

    localparam logic [1:0] FONT_42X16 = 2'd0;
    localparam logic [1:0] FONT_64X16 = 2'd1;
    localparam logic [1:0] FONT_32X8  = 2'd2;
    localparam logic [1:0] FONT_25X8  = 2'd3;

    localparam int FONT0_COLS = 42;
    localparam int FONT1_COLS = 64;
    localparam int FONT2_COLS = 32;
    localparam int FONT3_COLS = 25;
    localparam int TALL_ROWS  = 16;
    localparam int SHORT_ROWS = 8;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        char_code;
        logic signed [7:0] target_column;
        logic signed [7:0] target_row;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  cursor_column;
        logic [3:0]  cursor_row;
        logic [15:0] dirty_rows;
        logic [7:0]  scroll_total;
        logic [7:0]  cell_value;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_MOVE,
        CMD_READ,
        CMD_CLEAR_DIRTY,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       char_code;
        logic [COL_W-1:0] tcol;
        logic [ROW_W-1:0] trow;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    typedef struct packed {
        logic cmd_pop;
        logic init_busy;
    } back_ctl_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FLUSH,
        ST_FILL,
        ST_DONE
    } back_state_t;

    // Number of columns of a font mode, capped at the store width.
    function automatic logic [GEO_COL_W-1:0] geo_cols(input logic [1:0] mode);
        int raw;
        unique case (mode)
            FONT_42X16: raw = FONT0_COLS;
            FONT_64X16: raw = FONT1_COLS;
            FONT_32X8:  raw = FONT2_COLS;
            FONT_25X8:  raw = FONT3_COLS;
            default:    raw = FONT0_COLS;
        endcase
        if (raw > MAX_COLUMNS)
            raw = MAX_COLUMNS;
        return GEO_COL_W'(raw);
    endfunction

    // Number of rows of a font mode, capped at the store height.
    function automatic logic [GEO_ROW_W-1:0] geo_rows(input logic [1:0] mode);
        int raw;
        unique case (mode)
            FONT_42X16: raw = TALL_ROWS;
            FONT_64X16: raw = TALL_ROWS;
            FONT_32X8:  raw = SHORT_ROWS;
            FONT_25X8:  raw = SHORT_ROWS;
            default:    raw = TALL_ROWS;
        endcase
        if (raw > MAX_ROWS)
            raw = MAX_ROWS;
        return GEO_ROW_W'(raw);
    endfunction

    // Saturates a signed byte to the range 0..limit-1.
    function automatic logic [GEO_COL_W-1:0] clamp_target(input logic [7:0] raw,
                                                          input logic [GEO_COL_W-1:0] limit);
        logic [GEO_COL_W-1:0] res;
        if (raw[7])
            res = '0;
        else if (raw >= 8'(limit))
            res = limit - GEO_COL_W'(1);
        else
            res = GEO_COL_W'(raw);
        return res;
    endfunction

endpackage

[rtl/core/ttsb_front.sv]
// Command front end: accepts items, decodes and clamps them, and queues them for the back end.
module ttsb_front import ttsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] font_mode,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    input  back_ctl_t  back_ctl,
    output cmd_chan_t  cmd_chan
);

    cmd_t                q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic                accept;
    cmd_t                decoded;
    logic [GEO_COL_W-1:0] cols;
    logic [GEO_ROW_W-1:0] rows;

    assign cols   = geo_cols(font_mode);
    assign rows   = geo_rows(font_mode);
    assign full   = (cnt_reg == QCNT_W'(QUEUE_DEPTH)) || back_ctl.init_busy;
    assign accept = push && !full;

    // Opcode decode and target saturation happen here, so the back end sees clean commands.
    always_comb
    begin
        unique case (item.opcode)
            OP_PUT_CHAR:    decoded.kind = CMD_PUT;
            OP_NEWLINE:     decoded.kind = CMD_NEWLINE;
            OP_CLEAR:       decoded.kind = CMD_CLEAR;
            OP_MOVE:        decoded.kind = CMD_MOVE;
            OP_READ:        decoded.kind = CMD_READ;
            OP_CLEAR_DIRTY: decoded.kind = CMD_CLEAR_DIRTY;
            default:        decoded.kind = CMD_NOP;
        endcase
        decoded.char_code = item.char_code;
        decoded.tcol      = COL_W'(clamp_target(item.target_column, cols));
        decoded.trow      = ROW_W'(clamp_target(item.target_row, GEO_COL_W'(rows)));
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !back_ctl.cmd_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!accept && back_ctl.cmd_pop)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (back_ctl.cmd_pop)
                rd_reg <= rd_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_reg] <= decoded;
    end

    assign cmd_chan.valid = (cnt_reg != '0);
    assign cmd_chan.cmd   = q_reg[rd_reg];

endmodule

[rtl/core/ttsb_back.sv]
// Command back end: cursor state, cell memory sweeps and the result queue.
module ttsb_back import ttsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] font_mode,
    input  cmd_chan_t  cmd_chan,
    output back_ctl_t  back_ctl,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result
);

    back_state_t          state_reg, state_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [MAX_ROWS-1:0]  dirty_reg, dirty_next;
    logic [7:0]           scroll_reg, scroll_next;
    logic [7:0]           cell_reg, cell_next;
    logic [ADDR_W-1:0]    ptr_reg, ptr_next;
    logic [ADDR_W-1:0]    end_reg, end_next;
    logic [ADDR_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                 pend_valid_reg, pend_valid_next;

    logic [7:0]           mem [CELL_DEPTH];
    logic [7:0]           rd_data_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [7:0]           mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    logic [GEO_COL_W-1:0] cols;
    logic [GEO_ROW_W-1:0] rows;
    logic [COL_W-1:0]     sat_col;
    logic [ROW_W-1:0]     sat_row;
    logic [GEO_COL_W-1:0] next_col;
    logic [GEO_ROW_W-1:0] next_row;
    logic                 wrap;
    logic                 scroll_nl;
    logic                 scroll_put;
    logic [MAX_ROWS-1:0]  row_mask;
    logic [GEO_ROW_W-1:0] mul_row;
    logic [BASE_W-1:0]    row_base;
    logic [ADDR_W-1:0]    base_addr;
    logic [ADDR_W-1:0]    base_less_one;
    logic                 start;

    out_item_t            res_buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    res_wr_reg;
    logic [QPTR_W-1:0]    res_rd_reg;
    logic [QCNT_W-1:0]    res_cnt_reg;
    logic                 res_full;
    logic                 res_push;
    logic                 res_pop;
    out_item_t            res_item;

    assign cols  = geo_cols(font_mode);
    assign rows  = geo_rows(font_mode);
    assign start = (state_reg == ST_IDLE) && cmd_chan.valid;

    // The cursor is saturated to the current geometry before every command.
    assign sat_col    = ({1'b0, col_reg} >= cols) ? COL_W'(cols - GEO_COL_W'(1)) : col_reg;
    assign sat_row    = ({1'b0, row_reg} >= rows) ? ROW_W'(rows - GEO_ROW_W'(1)) : row_reg;
    assign next_col   = GEO_COL_W'(sat_col) + GEO_COL_W'(1);
    assign next_row   = GEO_ROW_W'(sat_row) + GEO_ROW_W'(1);
    assign wrap       = (next_col >= cols);
    assign scroll_nl  = (next_row >= rows);
    assign scroll_put = wrap && scroll_nl;
    assign row_mask   = MAX_ROWS'((32'd1 << rows) - 32'd1);

    // One small multiplier forms the start address of whichever row the command needs.
    always_comb
    begin
        unique case (cmd_chan.cmd.kind)
            CMD_PUT:     mul_row = GEO_ROW_W'(sat_row);
            CMD_NEWLINE: mul_row = scroll_nl ? GEO_ROW_W'(sat_row) : next_row;
            CMD_CLEAR:   mul_row = rows;
            CMD_READ:    mul_row = GEO_ROW_W'(cmd_chan.cmd.trow);
            default:     mul_row = GEO_ROW_W'(sat_row);
        endcase
    end

    assign row_base      = BASE_W'(mul_row) * BASE_W'(cols);
    assign base_addr     = row_base[ADDR_W-1:0];
    assign base_less_one = ADDR_W'(row_base - BASE_W'(1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                if (ptr_reg == ADDR_W'(CELL_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (cmd_chan.valid)
                begin
                    unique case (cmd_chan.cmd.kind)
                        CMD_PUT:     state_next = scroll_put ? ST_COPY : ST_DONE;
                        CMD_NEWLINE: state_next = scroll_nl ? ST_COPY : ST_FILL;
                        CMD_CLEAR:   state_next = ST_FILL;
                        CMD_READ:    state_next = ST_READ;
                        default:     state_next = ST_DONE;
                    endcase
                end
            ST_READ:
                state_next = ST_DONE;
            ST_COPY:
                if (ptr_reg == end_reg)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                state_next = ST_FILL;
            ST_FILL:
                if (ptr_reg == end_reg)
                    state_next = ST_DONE;
            ST_DONE:
                if (!res_full)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        dirty_next      = dirty_reg;
        scroll_next     = scroll_reg;
        cell_next       = cell_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        pend_addr_next  = pend_addr_reg;
        pend_valid_next = pend_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = BLANK_CELL;
        mem_raddr       = ptr_reg;
        res_push        = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = RESET_CELL;
                ptr_next  = ptr_reg + ADDR_W'(1);
            end
            ST_IDLE:
                if (cmd_chan.valid)
                begin
                    col_next        = sat_col;
                    row_next        = sat_row;
                    cell_next       = '0;
                    pend_valid_next = 1'b0;
                    unique case (cmd_chan.cmd.kind)
                        CMD_PUT:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = base_addr + ADDR_W'(sat_col);
                            mem_wdata  = cmd_chan.cmd.char_code;
                            dirty_next = dirty_reg | (MAX_ROWS'(1) << sat_row);
                            if (!wrap)
                                col_next = COL_W'(next_col);
                            else
                            begin
                                col_next = '0;
                                if (scroll_put)
                                begin
                                    dirty_next  = dirty_reg | row_mask;
                                    scroll_next = scroll_reg + 8'd1;
                                    ptr_next    = '0;
                                    end_next    = base_less_one;
                                end
                                else
                                    row_next = ROW_W'(next_row);
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (scroll_nl)
                            begin
                                // The scroll blanks the bottom row, which is the new row.
                                dirty_next  = dirty_reg | row_mask;
                                scroll_next = scroll_reg + 8'd1;
                                ptr_next    = '0;
                                end_next    = base_less_one;
                            end
                            else
                            begin
                                row_next   = ROW_W'(next_row);
                                dirty_next = dirty_reg | (MAX_ROWS'(1) << next_row);
                                ptr_next   = base_addr;
                                end_next   = base_addr + ADDR_W'(cols) - ADDR_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            dirty_next = dirty_reg | row_mask;
                            ptr_next   = '0;
                            end_next   = base_less_one;
                        end
                        CMD_MOVE:
                        begin
                            col_next = cmd_chan.cmd.tcol;
                            row_next = cmd_chan.cmd.trow;
                        end
                        CMD_READ:
                            mem_raddr = base_addr + ADDR_W'(cmd_chan.cmd.tcol);
                        CMD_CLEAR_DIRTY:
                            dirty_next = '0;
                        default:
                        begin
                        end
                    endcase
                end
            ST_READ:
                cell_next = rd_data_reg;
            ST_COPY:
            begin
                // Read one row ahead and write the byte back in the following cycle.
                mem_raddr       = ptr_reg + ADDR_W'(cols);
                mem_we          = pend_valid_reg;
                mem_waddr       = pend_addr_reg;
                mem_wdata       = rd_data_reg;
                pend_addr_next  = ptr_reg;
                pend_valid_next = 1'b1;
                ptr_next        = ptr_reg + ADDR_W'(1);
            end
            ST_FLUSH:
            begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr_reg;
                mem_wdata = rd_data_reg;
                ptr_next  = end_reg + ADDR_W'(1);
                end_next  = end_reg + ADDR_W'(cols);
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
            end
            ST_DONE:
                res_push = !res_full;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            dirty_reg      <= '0;
            scroll_reg     <= '0;
            ptr_reg        <= '0;
            end_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            dirty_reg      <= dirty_next;
            scroll_reg     <= scroll_next;
            ptr_reg        <= ptr_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg      <= cell_next;
        pend_addr_reg <= pend_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign res_item.cursor_column = col_reg;
    assign res_item.cursor_row    = row_reg;
    assign res_item.dirty_rows    = 16'(dirty_reg);
    assign res_item.scroll_total  = scroll_reg;
    assign res_item.cell_value    = cell_reg;

    assign res_full = (res_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (res_cnt_reg == '0);
    assign res_pop  = pop && !empty;
    assign result   = res_buf_reg[res_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (res_push)
                res_wr_reg <= res_wr_reg + QPTR_W'(1);
            if (res_pop)
                res_rd_reg <= res_rd_reg + QPTR_W'(1);
            if (res_push && !res_pop)
                res_cnt_reg <= res_cnt_reg + QCNT_W'(1);
            else if (!res_push && res_pop)
                res_cnt_reg <= res_cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            res_buf_reg[res_wr_reg] <= res_item;
    end

    assign back_ctl.cmd_pop   = start;
    assign back_ctl.init_busy = (state_reg == ST_INIT);

endmodule

[rtl/core/text_terminal_screen_buffer_core.sv]
// Top level of the text terminal screen buffer: font mode register, front end and back end.

// A character-cell screen store with a cursor, driven by a queue of commands. Each
// accepted command returns exactly one result (cursor, dirty-row mask, scroll count and,
// for a cell read, the character). The front end decodes and clamps commands and holds up
// to two of them; the back end executes one command at a time against a 1024-byte cell
// memory with one write port, and the results wait in a two-entry queue. Put char, move,
// clear dirty and unused opcodes go straight to their result, a cell read first reads the
// memory, a newline fills one row, a clear fills every row, and a scrolling command copies
// each row up and then fills the bottom row: the single memory write port sets this pace,
// since a scroll moves one byte per cycle and every fill writes one byte per cycle. After
// reset the back end zeroes the whole cell memory, during which full stays high; font mode
// writes are taken at any time but must only be issued while no command is in flight.
module text_terminal_screen_buffer_core import ttsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    logic [1:0] font_mode_reg;
    cmd_chan_t  cmd_chan;
    back_ctl_t  back_ctl;

    // The font mode selects the screen geometry for both halves of the design.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            font_mode_reg <= FONT_42X16;
        else if (cfg_we)
            font_mode_reg <= cfg_data;
    end

    ttsb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .font_mode (font_mode_reg),
        .push      (push),
        .full      (full),
        .item      (item),
        .back_ctl  (back_ctl),
        .cmd_chan  (cmd_chan)
    );

    ttsb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .font_mode (font_mode_reg),
        .cmd_chan  (cmd_chan),
        .back_ctl  (back_ctl),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

[rtl/core/ttsb_checker.sv]
// Port-level checker for the text terminal screen buffer and its bind statement.
module ttsb_checker import ttsb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input out_item_t  result,
    input logic       cfg_we,
    input logic [1:0] cfg_data
);

    logic [1:0] mode_reg;
    logic [2:0] outstanding_reg;
    logic [7:0] last_scroll_reg;
    logic       have_last_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= FONT_42X16;
            outstanding_reg <= '0;
            last_scroll_reg <= '0;
            have_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (in_xfer && !out_xfer)
                outstanding_reg <= outstanding_reg + 3'd1;
            else if (!in_xfer && out_xfer)
                outstanding_reg <= outstanding_reg - 3'd1;
            if (out_xfer)
            begin
                last_scroll_reg <= result.scroll_total;
                have_last_reg   <= 1'b1;
            end
        end
    end

    // A waiting result holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // No result appears without a command that is still owed one.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 3'd0 |-> empty)
        else $error("result without an outstanding command");

    // The reported cursor always lies inside the current geometry.
    a_col_in_geo: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> {1'b0, result.cursor_column} < geo_cols(mode_reg))
        else $error("cursor column outside the screen");

    a_row_in_geo: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> {1'b0, result.cursor_row} < geo_rows(mode_reg))
        else $error("cursor row outside the screen");

    // One command scrolls at most one line.
    a_scroll_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && have_last_reg |->
            (result.scroll_total == last_scroll_reg) ||
            (result.scroll_total == last_scroll_reg + 8'd1))
        else $error("scroll count jumped");

endmodule

bind text_terminal_screen_buffer_core ttsb_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
);
